// File: hw/rtl/bfi_pkg.sv
package bfi_pkg;

    // hash and element geometry
    localparam int NUM_HASHES         = 4;
    localparam int HASH_W             = 2;
    localparam int MAX_ELEMENT_LENGTH = 16;
    localparam int POS_W              = 4;
    localparam int LEN_W              = 5;

    // word widths
    localparam int COEFF_W = 64;
    localparam int SYM_W   = 8;
    localparam int CNT_W   = 32;

    // coefficient store, one entry per hash and symbol position
    localparam int COEFF_AW    = HASH_W + POS_W;
    localparam int COEFF_DEPTH = NUM_HASHES * MAX_ELEMENT_LENGTH;

    // filter store, bit index split into row and bit within row
    localparam int FILTER_AW = 16;
    localparam int ROW_W     = 64;
    localparam int BIT_W     = 6;
    localparam int ROW_AW    = FILTER_AW - BIT_W;
    localparam int ROWS      = 2 ** ROW_AW;

    localparam logic [COEFF_W-1:0] HASH_SEED = 64'd3203431780337;

    // item commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SYMBOL = 1'b1;

    // register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ELEMENT_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] ELEMENT_LENGTH_RESET = 5'd16;

endpackage

// File: hw/rtl/bfi_if.sv
interface bfi_req_if import bfi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [HASH_W-1:0]  hash_select;
    logic [POS_W-1:0]   position;
    logic [COEFF_W-1:0] coeff_value;
    logic [SYM_W-1:0]   element_value;

    modport source (
        output valid, command, hash_select, position, coeff_value, element_value,
        input  ready
    );
    modport sink (
        input  valid, command, hash_select, position, coeff_value, element_value,
        output ready
    );
endinterface

interface bfi_rsp_if import bfi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             inserted;
    logic [CNT_W-1:0] insert_count;

    modport source (
        output valid, inserted, insert_count,
        input  ready
    );
    modport sink (
        input  valid, inserted, insert_count,
        output ready
    );
endinterface

// File: hw/rtl/bloom_filter_insert.sv
// channel  dir  carries                                              word moved
// req      in   command, hash_select, position, coeff_value,         one load or one symbol
//               element_value
// rsp      out  inserted, insert_count                               one result per element
// apb      in   element_length at byte address 0                     one register write
//
// a load word is taken in idle and the block is ready again at once
// a symbol word reads, multiplies and accumulates per hash on the shared 64 x 9 multiplier
// the last symbol adds a bit test per hash, a bit set per hash if new, and the result post
// after reset all 1024 filter rows are swept clear one 64-bit row a cycle, req not ready
// a waiting result sits in the output register; a new result waits only if it is still untaken
module bloom_filter_insert import bfi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    bfi_req_if.sink            req,
    bfi_rsp_if.source          rsp
);

    typedef enum logic [3:0] {
        ST_CLEAR,    // sweep filter rows to zero
        ST_IDLE,     // take a word
        ST_COEF_RD,  // coefficient read issued for hash h
        ST_MUL,      // coefficient times symbol into product register
        ST_ACC,      // fold product into accumulator h
        ST_BIT_RD,   // filter row read for hash h
        ST_BIT_CHK,  // test the indexed bit
        ST_SET_RD,   // re-read row before setting
        ST_SET_WR,   // write row with bit set
        ST_RESULT    // post result once output register is free
    } state_t;

    state_t              state_reg, state_next;
    logic [HASH_W-1:0]   h_reg, h_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SYM_W:0]      sym1_reg, sym1_next;
    logic [COEFF_W-1:0]  prod_reg, prod_next;
    logic [COEFF_W-1:0]  acc_reg [NUM_HASHES];
    logic [COEFF_W-1:0]  acc_next [NUM_HASHES];
    logic                present_reg, present_next;
    logic [ROW_AW-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    elen_reg, elen_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                rsp_ins_reg, rsp_ins_next;
    logic [CNT_W-1:0]    rsp_cnt_reg, rsp_cnt_next;

    // coefficient store
    logic                coef_we;
    logic [COEFF_AW-1:0] coef_waddr;
    logic [COEFF_AW-1:0] coef_raddr;
    logic [COEFF_W-1:0]  coef_rdata;

    // filter store
    logic                filt_we;
    logic [ROW_AW-1:0]   filt_waddr;
    logic [ROW_W-1:0]    filt_wdata;
    logic [ROW_AW-1:0]   filt_raddr;
    logic [ROW_W-1:0]    filt_rdata;

    logic                       accept;
    logic                       cfg_write;
    logic [COEFF_W+SYM_W:0]     prod_full;
    logic [LEN_W-1:0]           eff_len;
    logic                       last_sym;
    logic [BIT_W-1:0]           bit_sel;
    logic [ROW_W-1:0]           bit_mask;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // register port: one register, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ELEMENT_LENGTH) ? PDATA_W'(elen_reg) : '0;

    // loads outside the table are dropped
    assign coef_we    = accept && (req.command == CMD_LOAD)
                     && ({1'b0, req.hash_select} < (HASH_W+1)'(NUM_HASHES))
                     && ({1'b0, req.position} < (POS_W+1)'(MAX_ELEMENT_LENGTH));
    assign coef_waddr = {req.hash_select, req.position};
    assign coef_raddr = {h_reg, pos_reg};

    bfi_ram #(
        .WIDTH (COEFF_W),
        .DEPTH (COEFF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (req.coeff_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // bit index is the accumulator modulo the filter size: its low bits
    assign filt_raddr = acc_reg[h_reg][FILTER_AW-1:BIT_W];
    assign bit_sel    = acc_reg[h_reg][BIT_W-1:0];
    assign bit_mask   = ROW_W'(1) << bit_sel;
    assign filt_we    = (state_reg == ST_CLEAR) || (state_reg == ST_SET_WR);
    assign filt_waddr = (state_reg == ST_CLEAR) ? clr_reg : filt_raddr;
    assign filt_wdata = (state_reg == ST_CLEAR) ? '0 : (filt_rdata | bit_mask);

    bfi_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_filt_ram (
        .clk   (clk),
        .we    (filt_we),
        .waddr (filt_waddr),
        .wdata (filt_wdata),
        .raddr (filt_raddr),
        .rdata (filt_rdata)
    );

    // shared multiplier, product wraps at 64 bits
    assign prod_full = coef_rdata * sym1_reg;

    // length register clamped to 1 .. max
    always_comb
    begin
        if (elen_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (elen_reg > LEN_W'(MAX_ELEMENT_LENGTH))
        begin
            eff_len = LEN_W'(MAX_ELEMENT_LENGTH);
        end
        else
        begin
            eff_len = elen_reg;
        end
    end

    assign last_sym = (({1'b0, pos_reg} + LEN_W'(1)) >= eff_len);

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        pos_next       = pos_reg;
        sym1_next      = sym1_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        present_next   = present_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        elen_next      = elen_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ins_next   = rsp_ins_reg;
        rsp_cnt_next   = rsp_cnt_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_write && (paddr[2] == REG_ELEMENT_LENGTH))
        begin
            elen_next = pwdata[LEN_W-1:0];
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (req.command == CMD_SYMBOL))
                begin
                    sym1_next  = {1'b0, req.element_value} + 1'b1;
                    h_next     = '0;
                    state_next = ST_COEF_RD;
                end
            end
            ST_COEF_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = prod_full[COEFF_W-1:0];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next[h_reg] = acc_reg[h_reg] ^ prod_reg;
                h_next          = h_reg + 1'b1;
                if (h_reg != HASH_W'(NUM_HASHES - 1))
                begin
                    state_next = ST_COEF_RD;
                end
                else if (last_sym)
                begin
                    h_next       = '0;
                    present_next = 1'b1;
                    state_next   = ST_BIT_RD;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BIT_RD:
            begin
                state_next = ST_BIT_CHK;
            end
            ST_BIT_CHK:
            begin
                // any clear bit makes the element new
                if (!filt_rdata[bit_sel])
                begin
                    present_next = 1'b0;
                end
                h_next = h_reg + 1'b1;
                if (h_reg != HASH_W'(NUM_HASHES - 1))
                begin
                    state_next = ST_BIT_RD;
                end
                else if (!present_next)
                begin
                    h_next     = '0;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SET_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SET_RD:
            begin
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                // rows shared by two hashes are re-read, so earlier sets survive
                h_next = h_reg + 1'b1;
                if (h_reg != HASH_W'(NUM_HASHES - 1))
                begin
                    state_next = ST_SET_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ins_next   = !present_reg;
                    rsp_cnt_next   = cnt_reg;
                    pos_next       = '0;
                    for (int h = 0; h < NUM_HASHES; h++)
                    begin
                        acc_next[h] = HASH_SEED;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            h_reg         <= '0;
            pos_reg       <= '0;
            sym1_reg      <= '0;
            prod_reg      <= '0;
            for (int h = 0; h < NUM_HASHES; h++)
            begin
                acc_reg[h] <= HASH_SEED;
            end
            present_reg   <= 1'b0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            elen_reg      <= ELEMENT_LENGTH_RESET;
            rsp_valid_reg <= 1'b0;
            rsp_ins_reg   <= 1'b0;
            rsp_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            pos_reg       <= pos_next;
            sym1_reg      <= sym1_next;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            present_reg   <= present_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            elen_reg      <= elen_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_ins_reg   <= rsp_ins_next;
            rsp_cnt_reg   <= rsp_cnt_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.inserted     = rsp_ins_reg;
    assign rsp.insert_count = rsp_cnt_reg;

endmodule

// File: hw/rtl/bfi_ram.sv
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bfi_checker.sv
module bfi_checker import bfi_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             req_command,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_inserted,
    input logic [CNT_W-1:0] rsp_insert_count
);

    // a symbol word keeps the block busy for the hash work
    a_symbol_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == CMD_SYMBOL) |=> !req_ready)
        else $error("ready straight after a symbol word");

    // insert count only ever steps by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (rsp_insert_count == $past(rsp_insert_count))
              || (rsp_insert_count == $past(rsp_insert_count) + 1'b1))
        else $error("insert count jumped");

    // a count change comes only with a new element result
    a_count_new: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_insert_count != $past(rsp_insert_count)) |-> rsp_valid && rsp_inserted)
        else $error("insert count moved without an insert");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_inserted) && $stable(rsp_insert_count))
        else $error("result changed while stalled");

endmodule

bind bloom_filter_insert bfi_checker u_bfi_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_command      (req.command),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_inserted     (rsp.inserted),
    .rsp_insert_count (rsp.insert_count)
);
